FILE: hdl/dlr_pkg.sv
// Shared types, constants and the per-axis step function for the DDA line rasteriser.
// No dependencies; used by every module of the block.
package dlr_pkg;

   localparam int COORD_W      = 6;
   localparam int COLOUR_W     = 8;
   localparam int IMG_SIZE_DEF = 64;
   localparam int QUEUE_DEPTH  = 2;

   typedef struct packed {
      logic [COORD_W-1:0]  start_row;
      logic [COORD_W-1:0]  start_col;
      logic [COORD_W-1:0]  abs_drow;
      logic [COORD_W-1:0]  abs_dcol;
      logic                neg_row;
      logic                neg_col;
      logic [COORD_W-1:0]  steps;
      logic [COLOUR_W-1:0] red;
      logic [COLOUR_W-1:0] green;
      logic [COLOUR_W-1:0] blue;
   } line_desc_type;

   typedef struct packed {
      logic [COORD_W-1:0] coord;
      logic [COORD_W-1:0] rem;
   } axis_type;

   // advance one axis by d/steps, keeping the remainder in [0, steps)
   function automatic axis_type step_axis(input logic [COORD_W-1:0] coord,
                                          input logic [COORD_W-1:0] rem,
                                          input logic [COORD_W-1:0] mag,
                                          input logic               neg,
                                          input logic [COORD_W-1:0] steps);
      logic signed [COORD_W+1:0] t;
      logic signed [COORD_W+1:0] s;
      axis_type                  r;
      s = $signed({2'b00, steps});
      if (neg) begin
         t = $signed({2'b00, rem}) - $signed({2'b00, mag});
         if (t < 0) begin
            t       = t + s;
            r.rem   = t[COORD_W-1:0];
            r.coord = coord - 1'b1;
         end else begin
            r.rem   = t[COORD_W-1:0];
            r.coord = coord;
         end
      end else begin
         t = $signed({2'b00, rem}) + $signed({2'b00, mag});
         if (t >= s) begin
            t       = t - s;
            r.rem   = t[COORD_W-1:0];
            r.coord = coord + 1'b1;
         end else begin
            r.rem   = t[COORD_W-1:0];
            r.coord = coord;
         end
      end
      return r;
   endfunction

endpackage

FILE: hdl/dlr_front.sv
// Front end: classifies a line request into start point, step magnitudes, directions and
// step count. Depends on dlr_pkg.
module dlr_front
   import dlr_pkg::*;
(
   input  logic [COORD_W-1:0]  start_row,
   input  logic [COORD_W-1:0]  start_col,
   input  logic [COORD_W-1:0]  end_row,
   input  logic [COORD_W-1:0]  end_col,
   input  logic [COLOUR_W-1:0] red,
   input  logic [COLOUR_W-1:0] green,
   input  logic [COLOUR_W-1:0] blue,
   output line_desc_type       desc
);

   logic               neg_row;
   logic               neg_col;
   logic [COORD_W-1:0] abs_drow;
   logic [COORD_W-1:0] abs_dcol;

   always_comb begin
      neg_row  = end_row < start_row;
      neg_col  = end_col < start_col;
      abs_drow = neg_row ? (start_row - end_row) : (end_row - start_row);
      abs_dcol = neg_col ? (start_col - end_col) : (end_col - start_col);

      desc.start_row = start_row;
      desc.start_col = start_col;
      desc.abs_drow  = abs_drow;
      desc.abs_dcol  = abs_dcol;
      desc.neg_row   = neg_row;
      desc.neg_col   = neg_col;
      desc.steps     = (abs_drow > abs_dcol) ? abs_drow : abs_dcol;
      desc.red       = red;
      desc.green     = green;
      desc.blue      = blue;
   end

endmodule

FILE: hdl/dlr_queue.sv
// Short queue of classified line descriptors between the front and back ends.
// Depends on dlr_pkg.
module dlr_queue
   import dlr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  line_desc_type push_desc,
   output logic          full,
   input  logic          pop,
   output logic          not_empty,
   output line_desc_type head_desc
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   line_desc_type      slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full      = count_ff == CNT_W'(QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign head_desc = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

FILE: hdl/dlr_back.sv
// Back end: remainder-accumulator pixel generator, drawn-map memory with clearing pass,
// and the result register. Depends on dlr_pkg.
module dlr_back
   import dlr_pkg::*;
#(
   parameter int IMG_SIZE = IMG_SIZE_DEF
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  line_desc_type       q_desc,
   output logic                q_pop,
   output logic                clearing,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [COORD_W-1:0]  rsp_pixel_row,
   output logic [COORD_W-1:0]  rsp_pixel_col,
   output logic [COLOUR_W-1:0] rsp_out_red,
   output logic [COLOUR_W-1:0] rsp_out_green,
   output logic [COLOUR_W-1:0] rsp_out_blue,
   output logic                rsp_newly_drawn,
   output logic                rsp_last_pixel
);

   localparam int DEPTH = IMG_SIZE * IMG_SIZE;
   localparam int AW    = $clog2(DEPTH);

   // generator stage
   logic               s1_v_ff;
   logic               s1_last_ff;
   logic [COORD_W-1:0] row_ff;
   logic [COORD_W-1:0] col_ff;
   logic [COORD_W-1:0] rrem_ff;
   logic [COORD_W-1:0] crem_ff;
   logic [COORD_W-1:0] idx_ff;
   line_desc_type      desc_ff;

   // map lookup stage
   logic                s2_v_ff;
   logic                s2_last_ff;
   logic                s2_inmap_ff;
   logic [AW-1:0]       s2_addr_ff;
   logic [COORD_W-1:0]  s2_row_ff;
   logic [COORD_W-1:0]  s2_col_ff;
   logic [COLOUR_W-1:0] s2_red_ff;
   logic [COLOUR_W-1:0] s2_green_ff;
   logic [COLOUR_W-1:0] s2_blue_ff;
   logic                rd_bit_ff;
   logic                fwd_ff;

   logic                out_v_ff;
   logic                clearing_ff;
   logic [AW-1:0]       clr_cnt_ff;
   logic                map_mem [DEPTH];

   logic                out_free, s2_adv, s2_free, s1_adv, s1_free;
   logic                s1_inmap;
   logic [AW-1:0]       s1_addr;
   axis_type            row_next, col_next;
   logic [COORD_W-1:0]  idx_in;

   assign out_free = !out_v_ff || !rsp_stall;
   assign s2_adv   = s2_v_ff && out_free;
   assign s2_free  = !s2_v_ff || s2_adv;
   assign s1_adv   = s1_v_ff && s2_free;
   assign s1_free  = !s1_v_ff || (s1_adv && s1_last_ff);
   assign q_pop    = q_valid && s1_free && !clearing_ff;
   assign clearing = clearing_ff;
   assign rsp_valid = out_v_ff;

   always_comb begin
      row_next = step_axis(row_ff, rrem_ff, desc_ff.abs_drow, desc_ff.neg_row, desc_ff.steps);
      col_next = step_axis(col_ff, crem_ff, desc_ff.abs_dcol, desc_ff.neg_col, desc_ff.steps);
      idx_in   = idx_ff + 1'b1;
      s1_inmap = (int'(row_ff) < IMG_SIZE) && (int'(col_ff) < IMG_SIZE);
      s1_addr  = AW'(int'(row_ff) * IMG_SIZE + int'(col_ff));
   end

   // clearing pass over the drawn map
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else if (clearing_ff) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == AW'(DEPTH - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            s1_v_ff <= 1'b1;
         end else if (s1_adv && s1_last_ff) begin
            s1_v_ff <= 1'b0;
         end
         if (s1_adv) begin
            s2_v_ff <= 1'b1;
         end else if (s2_adv) begin
            s2_v_ff <= 1'b0;
         end
         if (s2_adv) begin
            out_v_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   // load a new line or advance one step
   always_ff @(posedge clock) begin
      if (q_pop) begin
         desc_ff    <= q_desc;
         row_ff     <= q_desc.start_row;
         col_ff     <= q_desc.start_col;
         rrem_ff    <= '0;
         crem_ff    <= '0;
         idx_ff     <= '0;
         s1_last_ff <= q_desc.steps == '0;
      end else if (s1_adv) begin
         row_ff     <= row_next.coord;
         col_ff     <= col_next.coord;
         rrem_ff    <= row_next.rem;
         crem_ff    <= col_next.rem;
         idx_ff     <= idx_in;
         s1_last_ff <= idx_in == desc_ff.steps;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_last_ff  <= s1_last_ff;
         s2_inmap_ff <= s1_inmap;
         s2_addr_ff  <= s1_addr;
         s2_row_ff   <= row_ff;
         s2_col_ff   <= col_ff;
         s2_red_ff   <= desc_ff.red;
         s2_green_ff <= desc_ff.green;
         s2_blue_ff  <= desc_ff.blue;
         fwd_ff      <= s2_adv && s2_inmap_ff && (s2_addr_ff == s1_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         map_mem[clr_cnt_ff] <= 1'b0;
      end else if (s2_adv && s2_inmap_ff) begin
         map_mem[s2_addr_ff] <= 1'b1;
      end
      if (s1_adv && s1_inmap) begin
         rd_bit_ff <= map_mem[s1_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         rsp_pixel_row   <= s2_row_ff;
         rsp_pixel_col   <= s2_col_ff;
         rsp_out_red     <= s2_red_ff;
         rsp_out_green   <= s2_green_ff;
         rsp_out_blue    <= s2_blue_ff;
         rsp_newly_drawn <= s2_inmap_ff && !rd_bit_ff && !fwd_ff;
         rsp_last_pixel  <= s2_last_ff;
      end
   end

endmodule

FILE: hdl/dda_line_rasterizer_unit.sv
// Top level of the DDA line rasteriser: front end, descriptor queue and back end.
// Depends on dlr_pkg, dlr_front, dlr_queue and dlr_back.

// Each line request gives two endpoints and a colour; the block answers with steps+1 pixel
// responses (1 to 64), steps being the larger of the row and column distances, the last
// one marked. The back-end generator produces one pixel per cycle while rsp_stall is low,
// and queued lines follow one another with no gap; the first pixel of a line passes through
// the queue, the generator stage, the map lookup stage and the result register. Up to two
// classified lines wait in the queue while the generator works. After reset the drawn map
// (IMG_SIZE x IMG_SIZE bits, 4096 by default) is cleared one entry a cycle, and req_stall
// stays high until the clearing pass ends. Pixels outside the map are still emitted but
// leave the map alone and report newly_drawn as 0.
module dda_line_rasterizer_unit
   import dlr_pkg::*;
#(
   parameter int IMG_SIZE = IMG_SIZE_DEF
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [COORD_W-1:0]  req_start_row,
   input  logic [COORD_W-1:0]  req_start_col,
   input  logic [COORD_W-1:0]  req_end_row,
   input  logic [COORD_W-1:0]  req_end_col,
   input  logic [COLOUR_W-1:0] req_red,
   input  logic [COLOUR_W-1:0] req_green,
   input  logic [COLOUR_W-1:0] req_blue,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [COORD_W-1:0]  rsp_pixel_row,
   output logic [COORD_W-1:0]  rsp_pixel_col,
   output logic [COLOUR_W-1:0] rsp_out_red,
   output logic [COLOUR_W-1:0] rsp_out_green,
   output logic [COLOUR_W-1:0] rsp_out_blue,
   output logic                rsp_newly_drawn,
   output logic                rsp_last_pixel
);

   line_desc_type front_desc;
   line_desc_type head_desc;
   logic          q_full;
   logic          q_not_empty;
   logic          q_pop;
   logic          clearing;
   logic          push;

   assign req_stall = q_full || clearing;
   assign push      = req_valid && !req_stall;

   dlr_front u_front (
      .start_row (req_start_row),
      .start_col (req_start_col),
      .end_row   (req_end_row),
      .end_col   (req_end_col),
      .red       (req_red),
      .green     (req_green),
      .blue      (req_blue),
      .desc      (front_desc)
   );

   dlr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (front_desc),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_desc (head_desc)
   );

   dlr_back #(
      .IMG_SIZE (IMG_SIZE)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_not_empty),
      .q_desc          (head_desc),
      .q_pop           (q_pop),
      .clearing        (clearing),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_row   (rsp_pixel_row),
      .rsp_pixel_col   (rsp_pixel_col),
      .rsp_out_red     (rsp_out_red),
      .rsp_out_green   (rsp_out_green),
      .rsp_out_blue    (rsp_out_blue),
      .rsp_newly_drawn (rsp_newly_drawn),
      .rsp_last_pixel  (rsp_last_pixel)
   );

endmodule
